@@ sv/overwriting_ring_queue_top_macros.svh @@
// assertion macros shared by the ring queue rtl
// each macro samples on the rising edge of i_clk and is off while reset is low
`ifndef OVERWRITING_RING_QUEUE_TOP_MACROS_SVH
`define OVERWRITING_RING_QUEUE_TOP_MACROS_SVH

// condition holds at every edge
`define ORQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ORQ_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ORQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/orq_pkg.sv @@
`default_nettype none
package orq_pkg;

    // default ring storage depth
    localparam int DEPTH_DEF = 16;

    // element, register and counter widths
    localparam int ELEM_W = 8;
    localparam int SIZE_W = 5;
    localparam int CNT_W  = 4;

    // stream word layout
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 1;

    // queue size register
    localparam int                QSIZE_RESET = 16;
    localparam logic [SIZE_W-1:0] QSIZE_MIN   = SIZE_W'(2);
    localparam logic              REG_QUEUE_SIZE = 1'b0;

    // drain limit when max_count is zero
    localparam logic [CNT_W-1:0] RESULT_LIMIT = {CNT_W{1'b1}};

    // operation codes
    typedef enum logic [1:0] {
        K_ENQ   = 2'd0,
        K_DEQ   = 2'd1,
        K_PEEK  = 2'd2,
        K_DRAIN = 2'd3
    } t_kind;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_FIX,
        S_TAKE,
        S_RES
    } t_state;

endpackage
`default_nettype wire

@@ sv/orq_ram.sv @@
`default_nettype none
module orq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ sv/overwriting_ring_queue_top.sv @@
// enqueue: S_OP, S_FIX, S_RES; the next word is taken only back in S_IDLE
// dequeue and peek: S_OP, S_TAKE, S_RES; the next word is taken only back in S_IDLE
// dequeue, peek or drain on an empty queue: S_OP, S_RES, then back to S_IDLE
// drain: S_OP, S_TAKE, S_RES per element, sharing the ring increment unit and ram read port
// synchronous reset clears head, tail and pending result; queue size returns to 16
// (capped at DEPTH); slot ram contents are kept, no clearing pass
`default_nettype none
module overwriting_ring_queue_top #(
    parameter int DEPTH = orq_pkg::DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [2:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    // input words
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [orq_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // data_in, max_count, pad
    input  wire logic [orq_pkg::IN_TUSER_W-1:0] s_axis_tuser,  // kind
    // result words
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [orq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // data_out, available, taken
    output logic [orq_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,  // status
    output logic                                m_axis_tlast
);

    import orq_pkg::*;

    `include "overwriting_ring_queue_top_macros.svh"

    localparam int AW     = $clog2(DEPTH);
    localparam int MAXQ_I = (DEPTH > 31) ? 31 : DEPTH;
    localparam int CW     = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;
    localparam logic [SIZE_W-1:0] MAXQ = SIZE_W'(MAXQ_I);
    localparam logic [SIZE_W-1:0] QRST = (QSIZE_RESET > MAXQ_I) ? MAXQ : SIZE_W'(QSIZE_RESET);

    t_state              r_state, n_state;
    t_kind               r_kind;
    logic [ELEM_W-1:0]   r_din;
    logic [CNT_W-1:0]    r_limit;
    logic [CNT_W-1:0]    r_taken;
    logic                r_status;
    logic [ELEM_W-1:0]   r_val;
    logic [AW-1:0]       r_head;
    logic [AW-1:0]       r_tail;
    logic [SIZE_W-1:0]   r_qsize;

    logic                r_out_valid;
    logic [ELEM_W-1:0]   r_out_data;
    logic                r_out_status;
    logic [CNT_W-1:0]    r_out_avail;
    logic [CNT_W-1:0]    r_out_taken;
    logic                r_out_last;

    logic                w_in_acc;
    logic                w_cfg_wr;
    logic [SIZE_W-1:0]   w_wsize;
    logic [SIZE_W-1:0]   w_clamped;
    logic [AW-1:0]       w_ring_in;
    logic [CW-1:0]       w_ring_sum;
    logic [AW-1:0]       w_ring_next;
    logic [CW-1:0]       w_count;
    logic                w_empty;
    logic                w_last;
    logic                w_we;
    logic                w_re;
    logic                w_head_adv;
    logic                w_tail_adv;
    logic                w_take;
    logic                w_mark_empty;
    logic                w_mark_enq;
    logic                w_out_load;
    logic [ELEM_W-1:0]   w_rdata;
    logic [CNT_W-1:0]    w_maxc;

    // handshakes
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_QUEUE_SIZE);
    assign w_maxc   = s_axis_tdata[ELEM_W +: CNT_W];

    // queue size clamp to the range 2..DEPTH (at most 31)
    assign w_wsize   = pwdata[SIZE_W-1:0];
    assign w_clamped = (w_wsize < QSIZE_MIN) ? QSIZE_MIN :
                       (w_wsize > MAXQ)      ? MAXQ      : w_wsize;

    // shared ring increment and wrap unit
    assign w_ring_in   = (r_state == S_OP) ? r_head : r_tail;
    assign w_ring_sum  = CW'(w_ring_in) + CW'(1);
    assign w_ring_next = (w_ring_sum >= CW'(r_qsize)) ? '0 : w_ring_sum[AW-1:0];

    // elements held
    assign w_count = CW'(r_head) - CW'(r_tail) + ((r_head < r_tail) ? CW'(r_qsize) : '0);
    assign w_empty = (r_head == r_tail);

    // final result of the current word
    assign w_last = (r_kind != K_DRAIN) || r_status || (r_taken == r_limit) || w_empty;

    // slot store
    orq_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_head),
        .i_wdata (r_din),
        .i_re    (w_re),
        .i_raddr (r_tail),
        .o_rdata (w_rdata)
    );

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer next state and strobes
    always_comb begin
        n_state      = r_state;
        w_we         = 1'b0;
        w_re         = 1'b0;
        w_head_adv   = 1'b0;
        w_tail_adv   = 1'b0;
        w_take       = 1'b0;
        w_mark_empty = 1'b0;
        w_mark_enq   = 1'b0;
        w_out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_OP;
                end
            end
            S_OP: begin
                if (r_kind == K_ENQ) begin
                    w_we       = 1'b1;
                    w_head_adv = 1'b1;
                    w_mark_enq = 1'b1;
                    n_state    = S_FIX;
                end else if (w_empty) begin
                    w_mark_empty = 1'b1;
                    n_state      = S_RES;
                end else begin
                    w_re    = 1'b1;
                    n_state = S_TAKE;
                end
            end
            S_FIX: begin
                // head caught the tail: drop the oldest element
                w_tail_adv = w_empty;
                n_state    = S_RES;
            end
            S_TAKE: begin
                w_take     = 1'b1;
                w_tail_adv = (r_kind != K_PEEK);
                n_state    = S_RES;
            end
            S_RES: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_out_load = 1'b1;
                    n_state    = w_last ? S_IDLE : S_OP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // pointers and queue size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_qsize <= QRST;
        end else if (w_cfg_wr) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_qsize <= w_clamped;
        end else begin
            if (w_head_adv) begin
                r_head <= w_ring_next;
            end
            if (w_tail_adv) begin
                r_tail <= w_ring_next;
            end
        end
    end

    // working word registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind  <= t_kind'(s_axis_tuser);
            r_din   <= s_axis_tdata[ELEM_W-1:0];
            r_limit <= (w_maxc == '0) ? RESULT_LIMIT : w_maxc;
            r_taken <= '0;
        end
        if (w_mark_enq || w_mark_empty) begin
            r_val    <= '0;
            r_status <= w_mark_empty;
        end
        if (w_take) begin
            r_val    <= w_rdata;
            r_status <= 1'b0;
            if (r_kind == K_DRAIN) begin
                r_taken <= r_taken + CNT_W'(1);
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data   <= r_val;
            r_out_status <= r_status;
            r_out_avail  <= w_count[CNT_W-1:0];
            r_out_taken  <= r_taken;
            r_out_last   <= w_last;
        end
    end

    // ports
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_taken, r_out_avail, r_out_data};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_QUEUE_SIZE) ? 32'(r_qsize) : '0;

    // checks
    `ORQ_ASSERT_ALWAYS(a_head_in_ring, CW'(r_head) < CW'(r_qsize), "head outside ring")
    `ORQ_ASSERT_ALWAYS(a_tail_in_ring, CW'(r_tail) < CW'(r_qsize), "tail outside ring")
    `ORQ_ASSERT_IMPLY(a_drain_count,
        (r_state == S_RES) && (r_kind == K_DRAIN) && !r_status,
        (r_taken != '0) && (r_taken <= r_limit), "drain count out of range")
    `ORQ_ASSERT_NEXT(a_read_to_take,
        (r_state == S_OP) && (r_kind != K_ENQ) && !w_empty,
        r_state == S_TAKE, "ram read not followed by take")
    `ORQ_ASSERT_IMPLY(a_enq_nonempty,
        (r_state == S_RES) && (r_kind == K_ENQ),
        !r_status && !w_empty, "queue empty after enqueue")

endmodule
`default_nettype wire
